### rtl/sdsse_pkg.sv
// Shared constants and the digit glyph table for the signed decimal
// seven-segment encoder. No dependencies.
`timescale 1ns / 1ps

package sdsse_pkg;

  // Display geometry
  localparam int DigitCount = 4;
  localparam int IdxW       = (DigitCount > 1) ? $clog2(DigitCount) : 1;
  localparam int CmpW       = (IdxW > 2) ? IdxW : 2;

  // Field widths
  localparam int ValueW = 15;
  localparam int PointW = 2;
  localparam int SegW   = 8;

  // Divide by ten: q = (x * DivMul) >> DivShift, exact for x below 43699
  localparam int DivMulW  = 16;
  localparam logic [DivMulW-1:0] DivMul = 16'd52429;
  localparam int DivShift = 19;
  localparam int ProdW    = ValueW + DivMulW;

  // Operation codes
  localparam logic OpShow  = 1'b0;
  localparam logic OpClear = 1'b1;

  // Segment bit positions
  localparam logic [SegW-1:0] SegA  = 8'(1 << 0);
  localparam logic [SegW-1:0] SegB  = 8'(1 << 6);
  localparam logic [SegW-1:0] SegC  = 8'(1 << 5);
  localparam logic [SegW-1:0] SegD  = 8'(1 << 4);
  localparam logic [SegW-1:0] SegE  = 8'(1 << 3);
  localparam logic [SegW-1:0] SegF  = 8'(1 << 1);
  localparam logic [SegW-1:0] SegG  = 8'(1 << 2);
  localparam logic [SegW-1:0] SegDp = 8'(1 << 7);

  // Glyph for one decimal digit; codes above nine never occur
  function automatic logic [SegW-1:0] digit_glyph(input logic [3:0] d);
    logic [SegW-1:0] g;
    unique case (d)
      4'd0:    g = SegA | SegB | SegC | SegD | SegE | SegF;
      4'd1:    g = SegB | SegC;
      4'd2:    g = SegA | SegB | SegD | SegE | SegG;
      4'd3:    g = SegA | SegB | SegC | SegD | SegG;
      4'd4:    g = SegF | SegG | SegB | SegC;
      4'd5:    g = SegA | SegF | SegG | SegC | SegD;
      4'd6:    g = SegA | SegF | SegG | SegE | SegC | SegD;
      4'd7:    g = SegA | SegB | SegC;
      4'd8:    g = SegA | SegB | SegC | SegD | SegE | SegF | SegG;
      4'd9:    g = SegA | SegB | SegC | SegD | SegF | SegG;
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

### rtl/signed_decimal_seven_segment_encoder.sv
// Top level of the signed decimal seven-segment encoder.
// Depends on sdsse_pkg for widths, segment constants and the glyph table.
//
// Usage:
//   Input channel (in_valid / in_stall) carries op, value and
//   point_position. Output channel (out_valid / out_stall) carries one
//   segment byte per beat, least significant digit first, with last high
//   on the final byte of each run (latch strobe). Every input beat yields
//   DigitCount output beats; a clear request yields DigitCount blank bytes.
//   A negative value sends DigitCount-1 magnitude digits and then a minus.
//
// Timing:
//   The input beat is loaded into the working registers and each byte is
//   then registered into the output register; a run of DigitCount bytes
//   follows on consecutive cycles when the receiver does not stall. One
//   decimal digit is peeled off per output beat by a divide-by-ten through
//   a reciprocal multiply, and the next item is taken in the cycle its
//   predecessor's last byte is produced.
//
// Reset (rst, synchronous) clears busy, the digit index and out_valid.
// While out_stall and out_valid are high the output byte holds and digit work pauses;
// in_stall stays high until the current run's last byte is produced.
`timescale 1ns / 1ps

module signed_decimal_seven_segment_encoder (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               op,
  input  logic signed [sdsse_pkg::ValueW-1:0] value,
  input  logic        [sdsse_pkg::PointW-1:0] point_position,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic        [sdsse_pkg::SegW-1:0]   segments,
  output logic                               last
);
  import sdsse_pkg::*;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(DigitCount - 1);

  // Working registers for the item being sent
  logic                busy;
  logic [IdxW-1:0]     idx;
  logic [ValueW-1:0]   mag;
  logic                neg;
  logic                clr;
  logic [PointW-1:0]   point;

  // Datapath
  logic                take;
  logic                in_take;
  logic                at_last;
  logic [ProdW-1:0]    prod;
  logic [ValueW-1:0]   quot;
  logic [ValueW-1:0]   rem_full;
  logic [3:0]          digit;
  logic [CmpW-1:0]     idx_cmp;
  logic [CmpW-1:0]     point_cmp;
  logic [SegW-1:0]     seg_next;
  logic [ValueW-1:0]   mag_in;

  // Handshake
  assign take     = busy && (!out_valid || !out_stall);
  assign at_last  = (idx == LastIdx);
  assign in_stall = busy && !(take && at_last);
  assign in_take  = in_valid && !in_stall;

  // Magnitude of the incoming value; the most negative code gives 2^14
  assign mag_in = value[ValueW-1] ? (~value + ValueW'(1)) : value;

  // Peel the low decimal digit off the magnitude
  assign prod     = ProdW'(mag) * ProdW'(DivMul);
  assign quot     = ValueW'(prod >> DivShift);
  assign rem_full = mag - ((quot << 3) + (quot << 1));
  assign digit    = rem_full[3:0];

  assign idx_cmp   = CmpW'(idx);
  assign point_cmp = CmpW'(point);

  // Build the segment byte for this beat
  always_comb begin
    seg_next = '0;
    if (clr == OpClear) begin
      seg_next = '0;
    end else if (neg && at_last) begin
      seg_next = SegG;
    end else begin
      if (mag == '0 && idx_cmp > point_cmp) begin
        seg_next = '0;
      end else begin
        seg_next = digit_glyph(digit);
      end
      if (idx_cmp == point_cmp && point != '0) begin
        seg_next = seg_next | SegDp;
      end
    end
  end

  // Control: advance the digit index, drop busy after the last beat
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        out_valid <= 1'b1;
        idx       <= idx + IdxW'(1);
        if (at_last) begin
          busy <= 1'b0;
        end
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (in_take) begin
        busy <= 1'b1;
        idx  <= '0;
      end
    end
  end

  // Payload: load a new item, or shift the magnitude down one digit
  always_ff @(posedge clk) begin
    if (in_take) begin
      mag   <= mag_in;
      neg   <= value[ValueW-1];
      clr   <= op;
      point <= point_position;
    end else if (take) begin
      mag <= quot;
    end
    if (take) begin
      segments <= seg_next;
      last     <= at_last;
    end
  end

endmodule

### bench/tb.sv
// Self-checking bench for the signed decimal seven-segment encoder.
// Depends on sdsse_pkg and rtl/signed_decimal_seven_segment_encoder.sv.
`timescale 1ns / 1ps

module tb;
  import sdsse_pkg::*;

  localparam int QuietLimit = 1000;

  typedef struct packed {
    logic [SegW-1:0] segments;
    logic            last;
  } display_byte_t;

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_stall;
  logic                     op;
  logic signed [ValueW-1:0] value;
  logic        [PointW-1:0] point_position;
  logic                     out_valid;
  logic                     out_stall;
  logic        [SegW-1:0]   segments;
  logic                     last;

  display_byte_t pending_bytes[$];
  int            fail_count;
  int            quiet_cycles;
  bit            tx_idle_on;
  bit            rx_idle_on;
  int            rx_hold_req;

  // Segment patterns for the decimal digits 0..9
  logic [SegW-1:0] digit_segs [10];

  signed_decimal_seven_segment_encoder i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .op             (op),
    .value          (value),
    .point_position (point_position),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .segments       (segments),
    .last           (last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    digit_segs[0] = SegA | SegB | SegC | SegD | SegE | SegF;
    digit_segs[1] = SegB | SegC;
    digit_segs[2] = SegA | SegB | SegD | SegE | SegG;
    digit_segs[3] = SegA | SegB | SegC | SegD | SegG;
    digit_segs[4] = SegB | SegC | SegF | SegG;
    digit_segs[5] = SegA | SegC | SegD | SegF | SegG;
    digit_segs[6] = SegA | SegC | SegD | SegE | SegF | SegG;
    digit_segs[7] = SegA | SegB | SegC;
    digit_segs[8] = SegA | SegB | SegC | SegD | SegE | SegF | SegG;
    digit_segs[9] = SegA | SegB | SegC | SegD | SegF | SegG;
  end

  // Work out the bytes one request puts on the shift chain
  function automatic void push_display_bytes(input logic op_i,
                                             input logic signed [ValueW-1:0] v,
                                             input logic [PointW-1:0] pt);
    display_byte_t b;
    int            signed_v;
    int unsigned   mag;
    int unsigned   d;
    int            ndig;
    bit            neg;
    if (op_i == OpClear) begin
      for (int k = 0; k < DigitCount; k++) begin
        b.segments = '0;
        b.last     = (k == DigitCount - 1);
        pending_bytes.push_back(b);
      end
      return;
    end
    signed_v = v;
    neg      = v[ValueW-1];
    mag      = neg ? -signed_v : signed_v;
    ndig     = neg ? DigitCount - 1 : DigitCount;
    for (int k = 0; k < ndig; k++) begin
      d = mag % 10;
      // blank leading zeros above the point position
      if (mag == 0 && k > int'(pt))
        b.segments = '0;
      else
        b.segments = digit_segs[d];
      if (k == int'(pt) && pt != 0)
        b.segments = b.segments | SegDp;
      b.last = !neg && (k == DigitCount - 1);
      pending_bytes.push_back(b);
      mag = mag / 10;
    end
    if (neg) begin
      b.segments = SegG;
      b.last     = 1'b1;
      pending_bytes.push_back(b);
    end
  endfunction

  // Offer one request and hold it until the encoder takes the beat
  task automatic send_item(input logic op_i, input logic signed [ValueW-1:0] v,
                           input logic [PointW-1:0] pt);
    @(negedge clk);
    in_valid       <= 1'b1;
    op             <= op_i;
    value          <= v;
    point_position <= pt;
    do
      @(posedge clk);
    while (in_stall);
    push_display_bytes(op_i, v, pt);
  endtask

  // Drop valid with junk on the payload; n sets the length of the gap
  task automatic idle_gap(input int n);
    @(negedge clk);
    in_valid       <= 1'b0;
    op             <= 1'($urandom);
    value          <= ValueW'($urandom);
    point_position <= PointW'($urandom);
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic maybe_idle();
    if (tx_idle_on && $urandom_range(0, 3) == 0)
      idle_gap($urandom_range(1, 17));
  endtask

  // Drop valid, then wait until every predicted byte is out
  task automatic wait_drain();
    idle_gap(1);
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Draw a request: mostly in-range numbers, some small, some raw, some clears
  task automatic random_item(output logic op_o, output logic signed [ValueW-1:0] v,
                             output logic [PointW-1:0] pt);
    int pick;
    int num;
    pick = $urandom_range(0, 99);
    op_o = OpShow;
    pt   = PointW'($urandom);
    if (pick < 10) begin
      op_o = OpClear;
      num  = $urandom;
    end else if (pick < 60) begin
      num = $urandom_range(0, 10998) - 999;
    end else if (pick < 80) begin
      num = $urandom_range(0, 140) - 20;
    end else begin
      num = $urandom;
    end
    v = num[ValueW-1:0];
  endtask

  // Field extremes, every digit, the point positions and the minus corner cases
  task automatic test_special_cases();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_item(OpShow, 15'sd0, 2'd0);
    send_item(OpShow, 15'sd0, 2'd3);
    send_item(OpShow, 15'sd9999, 2'd0);
    send_item(OpShow, 15'sd16383, 2'd1);
    send_item(OpShow, -15'sd16384, 2'd2);
    send_item(OpShow, -15'sd999, 2'd3);
    send_item(OpShow, -15'sd1, 2'd0);
    send_item(OpShow, -15'sd5, 2'd2);
    send_item(OpShow, -15'sd1000, 2'd1);
    send_item(OpShow, 15'sd10000, 2'd0);
    send_item(OpShow, 15'sd1234, 2'd2);
    send_item(OpShow, 15'sd5678, 2'd1);
    send_item(OpShow, 15'sd90, 2'd3);
    send_item(OpShow, 15'sd7, 2'd1);
    send_item(OpClear, -15'sd1, 2'd3);
    send_item(OpClear, 15'sd0, 2'd0);
    send_item(OpShow, -15'sd40, 2'd1);
    wait_drain();
  endtask

  // Random traffic with idle bursts on both sides
  task automatic test_random_mix();
    logic                     o;
    logic signed [ValueW-1:0] v;
    logic        [PointW-1:0] p;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    repeat (250) begin
      maybe_idle();
      random_item(o, v, p);
      send_item(o, v, p);
    end
    wait_drain();
  endtask

  // Receiver holds off for a long stretch while requests keep coming
  task automatic test_output_hold();
    logic                     o;
    logic signed [ValueW-1:0] v;
    logic        [PointW-1:0] p;
    tx_idle_on  = 1'b0;
    rx_idle_on  = 1'b0;
    rx_hold_req = 200;
    repeat (12) begin
      random_item(o, v, p);
      send_item(o, v, p);
    end
    wait_drain();
  endtask

  // Sender goes quiet until every byte is out, then resumes
  task automatic test_sender_pause();
    logic                     o;
    logic signed [ValueW-1:0] v;
    logic        [PointW-1:0] p;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    repeat (8) begin
      random_item(o, v, p);
      send_item(o, v, p);
    end
    idle_gap(1);
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (8) begin
      maybe_idle();
      random_item(o, v, p);
      send_item(o, v, p);
    end
  endtask

  // Back-to-back requests with the receiver always ready
  task automatic test_full_rate();
    logic                     o;
    logic signed [ValueW-1:0] v;
    logic        [PointW-1:0] p;
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (60) begin
      random_item(o, v, p);
      send_item(o, v, p);
    end
    idle_gap(1);
  endtask

  // Receiver: long hold on request, otherwise random stall bursts
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req > 0) begin
        n           = rx_hold_req;
        rx_hold_req = 0;
        out_stall <= 1'b1;
        repeat (n - 1) @(negedge clk);
      end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 17);
        out_stall <= 1'b1;
        repeat (n - 1) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each output beat with the oldest predicted byte
  always @(posedge clk) begin
    display_byte_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_bytes.size() == 0) begin
        $error("unexpected byte: segments %h last %b", segments, last);
        fail_count++;
      end else begin
        want = pending_bytes.pop_front();
        if (segments !== want.segments) begin
          $error("segments: expected %h, actual %h", want.segments, segments);
          fail_count++;
        end
        if (last !== want.last) begin
          $error("last: expected %b, actual %b", want.last, last);
          fail_count++;
        end
      end
    end
  end

  // Abort when neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("[signed_decimal_seven_segment_encoder] ERROR");
      $finish;
    end
  end

  initial begin
    fail_count     = 0;
    quiet_cycles   = 0;
    tx_idle_on     = 1'b0;
    rx_idle_on     = 1'b0;
    rx_hold_req    = 0;
    rst            = 1'b1;
    in_valid       = 1'b0;
    op             = OpShow;
    value          = '0;
    point_position = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_special_cases();
    test_random_mix();
    test_output_hold();
    test_sender_pause();
    test_full_rate();

    wait_drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("[signed_decimal_seven_segment_encoder] OK");
    else
      $display("[signed_decimal_seven_segment_encoder] ERROR");
    $finish;
  end

endmodule
